FILE: rtl/core/glb_pkg.sv
package glb_pkg;

  localparam int MAX_CHARS_DEF = 64;
  localparam int RESULT_LIMIT  = 64;

  localparam logic [1:0] REG_LIMIT_EN = 2'd0;
  localparam logic [1:0] REG_PLATE    = 2'd1;
  localparam logic [1:0] REG_INDENT   = 2'd2;
  localparam logic [1:0] REG_LEADING  = 2'd3;

  typedef struct packed {
    logic [15:0]        char_code;
    logic [15:0]        char_width;
    logic [14:0]        char_ascent;
    logic signed [15:0] char_descent;
    logic               last_char;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         line_first;
    logic [5:0]         line_final;
    logic [19:0]        line_width_out;
    logic [14:0]        line_ascent_out;
    logic signed [15:0] line_descent_out;
    logic [23:0]        section_height;
    logic [19:0]        section_width;
    logic               final_line;
  } out_item_t;

  // Stored character entry
  typedef struct packed {
    logic [15:0]        code;
    logic [15:0]        width;
    logic [14:0]        ascent;
    logic signed [15:0] descent;
  } glyph_t;

  // Character class flags
  typedef struct packed {
    logic latin;
    logic digit;
    logic cjk;
    logic punct;
    logic conn;
    logic open;
    logic prefix;
    logic space;
  } cls_t;

  function automatic logic rng(input logic [15:0] c, input logic [15:0] lo,
                               input logic [15:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic cls_t classify(input logic [15:0] c);
    cls_t k;
    logic lo7;
    logic lo8;
    lo7 = (c <= 16'h007F);
    lo8 = (c <= 16'h00FF);
    k.digit = rng(c, 16'h30, 16'h39);
    if (lo7) begin
      k.latin = rng(c, 16'h41, 16'h5A) || rng(c, 16'h61, 16'h7A);
    end else begin
      k.latin = rng(c, 16'hC0, 16'h24F) || rng(c, 16'h1E00, 16'h1EFF) ||
                rng(c, 16'h2C60, 16'h2C7F) || rng(c, 16'hA720, 16'hA7FF) ||
                rng(c, 16'hFF21, 16'hFF3A) || rng(c, 16'hFF41, 16'hFF5A);
    end
    if (rng(c, 16'h1100, 16'h11FF) || rng(c, 16'h2E80, 16'h2FFF) ||
        rng(c, 16'h3040, 16'h9FBF) || rng(c, 16'hAC00, 16'hD7AF) ||
        rng(c, 16'hF900, 16'hFAFF) || rng(c, 16'hFE30, 16'hFE4F)) begin
      k.cjk = 1'b1;
    end else if (rng(c, 16'h3000, 16'h303F)) begin
      k.cjk = (c == 16'h3005) || (c == 16'h3006) || rng(c, 16'h3021, 16'h3029) ||
              rng(c, 16'h3031, 16'h3035);
    end else begin
      k.cjk = rng(c, 16'hFF66, 16'hFF9D);
    end
    if (lo7) begin
      k.punct = rng(c, 16'h01, 16'h04) || c == 16'h21 || c == 16'h22 ||
                rng(c, 16'h27, 16'h29) || rng(c, 16'h2C, 16'h2F) ||
                c == 16'h3A || c == 16'h3B || c == 16'h3F || c == 16'h5B ||
                c == 16'h5D || c == 16'h7B || c == 16'h7D;
    end else if (lo8) begin
      k.punct = c == 16'h82 || c == 16'h84 || c == 16'h85 || rng(c, 16'h91, 16'h94) ||
                c == 16'h96 || c == 16'hB4 || c == 16'hB8;
    end else if (rng(c, 16'h2000, 16'h206F)) begin
      k.punct = rng(c, 16'h2010, 16'h2013) || rng(c, 16'h2018, 16'h201F) ||
                rng(c, 16'h2032, 16'h2037) || rng(c, 16'h203C, 16'h203E) ||
                c == 16'h2044;
    end else if (rng(c, 16'h3000, 16'h303F)) begin
      k.punct = rng(c, 16'h3001, 16'h3003) || c == 16'h3005 ||
                rng(c, 16'h3009, 16'h3011) || rng(c, 16'h3014, 16'h301B) ||
                rng(c, 16'h301D, 16'h301F);
    end else if (rng(c, 16'hFE50, 16'hFE6F)) begin
      k.punct = rng(c, 16'hFE50, 16'hFE5E) || c == 16'hFE63;
    end else if (rng(c, 16'hFF00, 16'hFFEF)) begin
      k.punct = c == 16'hFF01 || c == 16'hFF02 || rng(c, 16'hFF07, 16'hFF09) ||
                c == 16'hFF0C || c == 16'hFF0E || c == 16'hFF0F || c == 16'hFF1A ||
                c == 16'hFF1B || c == 16'hFF1F || c == 16'hFF3B || c == 16'hFF3D ||
                c == 16'hFF40 || rng(c, 16'hFF5B, 16'hFF5D) ||
                rng(c, 16'hFF61, 16'hFF65) || c == 16'hFF9E || c == 16'hFF9F;
    end else begin
      k.punct = 1'b0;
    end
    k.conn = c == 16'h06 || c == 16'h27 || rng(c, 16'h2C, 16'h2F);
    if (lo7) begin
      k.open = c == 16'h01 || c == 16'h03 || c == 16'h28 || c == 16'h5B || c == 16'h7B;
    end else begin
      k.open = c == 16'h300A || c == 16'h300C || c == 16'h300E || c == 16'h3010 ||
               c == 16'h3014 || c == 16'h3016 || c == 16'h3018 || c == 16'h301A ||
               c == 16'hFF08 || c == 16'hFF3B || c == 16'hFF5B || c == 16'hFF62;
    end
    k.prefix = c == 16'h24 || c == 16'h80 || rng(c, 16'hA2, 16'hA5) ||
               rng(c, 16'h20A0, 16'h20CF) || c == 16'hFE69 || c == 16'hFF04 ||
               c == 16'hFFE0 || c == 16'hFFE1 || c == 16'hFFE5 || c == 16'hFFE6 ||
               c == 16'h2116;
    k.space = c == 16'h0020 || c == 16'h3000;
    return k;
  endfunction

  function automatic logic break_between(input cls_t p, input cls_t c);
    logic r;
    if ((p.latin || p.digit) && (c.latin || c.digit)) r = 1'b0;
    else if (c.space || c.punct) r = 1'b0;
    else if (p.conn || c.conn) r = 1'b0;
    else if (p.space || p.punct) r = 1'b1;
    else if (p.prefix) r = 1'b0;
    else if (c.prefix || c.cjk) r = 1'b1;
    else r = p.cjk;
    return r;
  endfunction

endpackage

FILE: rtl/core/greedy_line_breaker.sv
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_ready  | glb_pkg::in_item_t
// out_     | output    | out_valid/out_ready| glb_pkg::out_item_t
// cfg_     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// Loading takes one character per cycle while in the load state; the store write port sets that.
// Breaking visits each character with a store read state and then an update
// state, plus revisits after each back-up to a break opportunity, and ends with a tail state.
// A line result is held in an output register until taken; the scan stalls
// while that register holds a visible result that is not taken. Configuration is taken only while idle.
// Reset is synchronous, active low, and clears all control state; the store
// content is not cleared.
module greedy_line_breaker #(
  parameter int MAX_CHARS = glb_pkg::MAX_CHARS_DEF,
  localparam int AW = $clog2(MAX_CHARS),
  localparam int CW = $clog2(MAX_CHARS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  glb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output glb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_READ = 4'b0010,
    S_STEP = 4'b0100,
    S_TAIL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic               limit_en_r;
  logic [19:0]        plate_r, indent_r;
  logic signed [15:0] leading_r;

  logic [CW-1:0]      count_r, scan_r, head_r, bstart_r, cnt_on_r, opp_r;
  logic               opened_r;
  logic [19:0]        rw_r, bw_r, wmax_r;
  logic [14:0]        ra_r, ba_r;
  logic signed [15:0] rd_r, bd_r;
  logic [23:0]        ht_r;
  logic [6:0]         nres_r;
  logic [15:0]        prev_code_r;
  logic [15:0]        bprev_r;

  logic               ov_r;
  logic               hold_r;
  glb_pkg::out_item_t ob_r;

  glb_pkg::glyph_t    cur;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;

  // Accept configuration only while idle with an empty store
  assign cfg_ready = (state_r == S_LOAD) && (count_r == '0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_en_r <= 1'b0;
      plate_r    <= '0;
      indent_r   <= '0;
      leading_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        glb_pkg::REG_LIMIT_EN: limit_en_r <= cfg_data[0];
        glb_pkg::REG_PLATE:    plate_r    <= cfg_data;
        glb_pkg::REG_INDENT:   indent_r   <= cfg_data;
        glb_pkg::REG_LEADING:  leading_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_LOAD);
  assign wr_en    = in_valid && in_ready && (count_r < CW'(MAX_CHARS));

  // Read address: scan position; previous code held in a register
  assign rd_addr = scan_r[AW-1:0];

  glb_store #(.MAX_CHARS(MAX_CHARS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_data.char_code, in_data.char_width, in_data.char_ascent,
               in_data.char_descent}),
    .rd_addr (rd_addr),
    .rd_data (cur)
  );

  // Step datapath
  logic [19:0]        tw;
  glb_pkg::cls_t      kc, kp;
  logic               full, opened_n, over;
  logic [14:0]        a1;
  logic signed [15:0] d1;
  logic [20:0]        sum;
  logic               emit_ok;

  assign tw  = (plate_r > indent_r) ? plate_r - indent_r : 20'd0;
  assign kc  = glb_pkg::classify(cur.code);
  assign kp  = glb_pkg::classify((scan_r == '0) ? cur.code : prev_code_r);
  assign a1  = (cur.ascent > ra_r) ? cur.ascent : ra_r;
  assign d1  = (cur.descent < rd_r) ? cur.descent : rd_r;
  assign sum = {1'b0, rw_r} + {4'd0, cur.width};
  assign over = limit_en_r && (tw != '0) && (sum > {1'b0, tw});
  assign emit_ok = !ov_r || hold_r || out_ready;

  always_comb begin
    full = 1'b0;
    opened_n = opened_r;
    if (!opened_r) begin
      if (kc.open) begin
        opened_n = 1'b1;
        full = 1'b1;
      end else if (glb_pkg::break_between(kp, kc)) begin
        full = 1'b1;
      end
    end else if (!kc.space && !kc.open) begin
      opened_n = 1'b0;
    end
  end

  // Commit helper values
  logic [19:0]        cw_width;
  logic [14:0]        cw_asc;
  logic signed [15:0] cw_desc;
  logic [CW-1:0]      cw_last, scan_after;
  logic signed [26:0] hsum;
  logic [23:0]        h_new;
  logic [CW-1:0]      opp_inc;
  logic [CW-1:0]      cnt_inc;

  always_comb begin
    opp_inc = opp_r + ((full && cnt_on_r != '0) ? CW'(1) : CW'(0));
    cnt_inc = cnt_on_r + CW'(1);
    cw_width = rw_r;
    cw_asc = a1;
    cw_desc = d1;
    scan_after = scan_r;
    if (opp_inc != '0) begin
      scan_after = full ? scan_r : bstart_r;
      cw_width = full ? rw_r : bw_r;
      cw_asc = full ? a1 : ba_r;
      cw_desc = full ? d1 : bd_r;
    end
    if (cnt_inc == CW'(1)) begin
      cw_width = {4'd0, cur.width};
      scan_after = scan_after + CW'(1);
    end
    cw_last = scan_after - CW'(1);
  end

  // Height accumulate for the line being committed (tail uses running values)
  logic [19:0]        c_w;
  logic [14:0]        c_a;
  logic signed [15:0] c_d;
  assign c_w = (state_r == S_TAIL) ? rw_r : cw_width;
  assign c_a = (state_r == S_TAIL) ? ra_r : cw_asc;
  assign c_d = (state_r == S_TAIL) ? rd_r : cw_desc;
  assign hsum = $signed({3'b0, ht_r}) + $signed({12'd0, c_a}) +
                27'(leading_r) - 27'(c_d);
  assign h_new = hsum[26] ? 24'd0 : (|hsum[25:24] ? 24'hFFFFFF : hsum[23:0]);

  logic [19:0] wmax_new;
  assign wmax_new = (c_w > wmax_r) ? c_w : wmax_r;

  logic commit, do_step, emit, last_line;
  logic [CW-1:0] c_first, c_last;
  assign do_step = (state_r == S_STEP) && emit_ok;
  assign commit  = (do_step && over) ||
                   ((state_r == S_TAIL) && emit_ok && (head_r < count_r));
  assign emit    = commit && (nres_r < 7'(glb_pkg::RESULT_LIMIT));
  // A step commit that reaches the end of the section is its last line
  assign last_line = (state_r == S_TAIL) || (scan_after >= count_r);
  assign c_first = head_r;
  assign c_last  = (state_r == S_TAIL) ? count_r - CW'(1) : cw_last;

  // Control and line state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (in_valid && in_data.last_char) state_nxt = S_READ;
      S_READ: state_nxt = S_STEP;
      S_STEP: begin
        if (emit_ok) begin
          if ((over ? scan_after : scan_r + CW'(1)) < count_r) state_nxt = S_READ;
          else state_nxt = S_TAIL;
        end
      end
      S_TAIL: if (emit_ok) state_nxt = S_LOAD;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_LOAD;
      count_r  <= '0;
      scan_r   <= '0;
      head_r   <= '0;
      bstart_r <= '0;
      cnt_on_r <= '0;
      opp_r    <= '0;
      opened_r <= 1'b0;
      rw_r <= '0; bw_r <= '0; wmax_r <= '0;
      ra_r <= '0; ba_r <= '0; rd_r <= '0; bd_r <= '0;
      ht_r <= '0; nres_r <= '0;
      ov_r <= 1'b0;
      hold_r <= 1'b0;
      prev_code_r <= '0;
      bprev_r <= '0;
    end else begin
      state_r <= state_nxt;
      // Load a character
      if (wr_en) count_r <= count_r + CW'(1);
      if (state_r == S_LOAD && in_valid && in_data.last_char) begin
        scan_r <= '0; head_r <= '0; bstart_r <= '0; opened_r <= 1'b0;
        cnt_on_r <= '0; opp_r <= '0;
        rw_r <= '0; ra_r <= '0; rd_r <= '0;
        bw_r <= '0; ba_r <= '0; bd_r <= '0;
        ht_r <= '0; wmax_r <= '0; nres_r <= '0;
      end
      // Process one stored character
      if (do_step) begin
        opened_r <= opened_n;
        if (full) begin
          bstart_r <= scan_r; bw_r <= rw_r; ba_r <= a1; bd_r <= d1;
          bprev_r <= prev_code_r;
        end
        if (over) begin
          scan_r   <= scan_after;
          head_r   <= scan_after;
          rw_r <= '0; ra_r <= '0; rd_r <= '0;
          cnt_on_r <= '0; opp_r <= '0;
          // Track the code just before the resume point
          if (cnt_inc == CW'(1)) prev_code_r <= cur.code;
          else if (opp_inc != '0 && !full) prev_code_r <= bprev_r;
        end else begin
          rw_r     <= sum[20] ? 20'hFFFFF : sum[19:0];
          ra_r     <= a1; rd_r <= d1;
          cnt_on_r <= cnt_inc; opp_r <= opp_inc;
          scan_r   <= scan_r + CW'(1);
          prev_code_r <= cur.code;
        end
      end
      if (state_r == S_TAIL && emit_ok) count_r <= '0;
      // Emit a line
      if (commit) begin
        ht_r   <= h_new;
        wmax_r <= wmax_new;
      end
      if (emit) begin
        nres_r <= nres_r + 7'd1;
        ob_r.line_first       <= 6'(c_first);
        ob_r.line_final       <= 6'(c_last);
        ob_r.line_width_out   <= c_w;
        ob_r.line_ascent_out  <= c_a;
        ob_r.line_descent_out <= c_d;
        ob_r.section_height   <= last_line ? h_new : 24'd0;
        ob_r.section_width    <= last_line ? wmax_new : 20'd0;
        ob_r.final_line       <= last_line;
        // Hold the last allowed result until the section totals are known
        if (!last_line && nres_r == 7'(glb_pkg::RESULT_LIMIT - 1)) hold_r <= 1'b1;
      end
      // Stamp totals onto a held result at the end of the section
      if (state_r == S_TAIL && hold_r) begin
        ob_r.section_height <= commit ? h_new : ht_r;
        ob_r.section_width  <= commit ? wmax_new : wmax_r;
        ob_r.final_line     <= 1'b1;
        hold_r <= 1'b0;
      end
      if (emit) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
    end
  end

  always_comb begin
    out_data = ob_r;
  end
  assign out_valid = ov_r && !hold_r;

endmodule

FILE: rtl/core/glb_store.sv
// Character store: one write port, one registered read port
module glb_store #(
  parameter int MAX_CHARS = glb_pkg::MAX_CHARS_DEF,
  localparam int AW = $clog2(MAX_CHARS)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  glb_pkg::glyph_t wr_data,
  input  logic [AW-1:0]   rd_addr,
  output glb_pkg::glyph_t rd_data
);

  glb_pkg::glyph_t mem [MAX_CHARS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/glb_checker.sv
module glb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input glb_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input glb_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // A line's first index does not exceed its final index
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_first <= out_data.line_final)
    else $error("line indices reversed");

endmodule

bind greedy_line_breaker glb_checker u_glb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 20000;
  localparam longint SAT20   = 64'hFFFFF;
  localparam longint SAT24   = 64'hFFFFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  glb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  glb_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = glb_pkg::REG_LIMIT_EN;
  logic [19:0] cfg_data = '0;

  greedy_line_breaker u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Register settings used by the run
  typedef struct {
    logic        wrap_en;
    logic [19:0] plate;
    logic [19:0] indent;
    logic [15:0] leading;
  } setting_t;

  setting_t settings[7] = '{
    '{1'b0, 20'h00000, 20'h00000, 16'h0000},
    '{1'b1, 20'h00100, 20'h00040, 16'h0010},
    '{1'b1, 20'h00300, 20'h00080, 16'h8000},
    '{1'b1, 20'h00040, 20'hFFFFF, 16'h7FFF},
    '{1'b1, 20'hFFFFF, 20'h00000, 16'hFFFF},
    '{1'b0, 20'h00200, 20'h00010, 16'h7FFF},
    '{1'b1, 20'h00600, 20'h00100, 16'h0020}
  };

  // Shadow configuration
  logic        sh_wrap_en;
  longint      sh_plate, sh_indent, sh_leading;

  // Shadow character store and breaking state
  longint st_code[STORE_DEPTH], st_wid[STORE_DEPTH];
  longint st_asc[STORE_DEPTH], st_dsc[STORE_DEPTH];
  int     stored_chars;
  longint run_w, run_a, run_d, sec_height, sec_width;
  glb_pkg::out_item_t section_lines[$];
  glb_pkg::out_item_t pending_lines[$];

  int  errors = 0;
  int  chars_sent = 0, sections_sent = 0, lines_seen = 0;
  int  idle_cycles = 0;
  bit  burst_in = 0, wide_mode = 0;

  // Character classes
  function automatic bit cls_latin(longint c);
    if (c <= 'h7F) return c inside {['h41:'h5A], ['h61:'h7A]};
    return c inside {['hC0:'h24F], ['h1E00:'h1EFF], ['h2C60:'h2C7F], ['hA720:'hA7FF],
                     ['hFF21:'hFF3A], ['hFF41:'hFF5A]};
  endfunction

  function automatic bit cls_digit(longint c);
    return c inside {['h30:'h39]};
  endfunction

  function automatic bit cls_cjk(longint c);
    if (c inside {['h1100:'h11FF], ['h2E80:'h2FFF], ['h3040:'h9FBF], ['hAC00:'hD7AF],
                  ['hF900:'hFAFF], ['hFE30:'hFE4F]}) return 1;
    if (c inside {['h3000:'h303F]})
      return c inside {'h3005, 'h3006, ['h3021:'h3029], ['h3031:'h3035]};
    return c inside {['hFF66:'hFF9D]};
  endfunction

  function automatic bit cls_punct(longint c);
    if (c <= 'h7F)
      return c inside {['h01:'h04], 'h21, 'h22, ['h27:'h29], ['h2C:'h2F], 'h3A, 'h3B,
                       'h3F, 'h5B, 'h5D, 'h7B, 'h7D};
    if (c <= 'hFF) return c inside {'h82, 'h84, 'h85, ['h91:'h94], 'h96, 'hB4, 'hB8};
    if (c inside {['h2000:'h206F]})
      return c inside {['h2010:'h2013], ['h2018:'h201F], ['h2032:'h2037],
                       ['h203C:'h203E], 'h2044};
    if (c inside {['h3000:'h303F]})
      return c inside {['h3001:'h3003], 'h3005, ['h3009:'h3011], ['h3014:'h301B],
                       ['h301D:'h301F]};
    if (c inside {['hFE50:'hFE6F]}) return c inside {['hFE50:'hFE5E], 'hFE63};
    if (c inside {['hFF00:'hFFEF]})
      return c inside {'hFF01, 'hFF02, ['hFF07:'hFF09], 'hFF0C, 'hFF0E, 'hFF0F, 'hFF1A,
                       'hFF1B, 'hFF1F, 'hFF3B, 'hFF3D, 'hFF40, ['hFF5B:'hFF5D],
                       ['hFF61:'hFF65], 'hFF9E, 'hFF9F};
    return 0;
  endfunction

  function automatic bit cls_conn(longint c);
    return c inside {'h06, 'h27, ['h2C:'h2F]};
  endfunction

  function automatic bit cls_open(longint c);
    if (c <= 'h7F) return c inside {'h01, 'h03, 'h28, 'h5B, 'h7B};
    return c inside {'h300A, 'h300C, 'h300E, 'h3010, 'h3014, 'h3016, 'h3018, 'h301A,
                     'hFF08, 'hFF3B, 'hFF5B, 'hFF62};
  endfunction

  function automatic bit cls_prefix(longint c);
    return c inside {'h24, 'h80, ['hA2:'hA5], ['h20A0:'h20CF], 'hFE69, 'hFF04, 'hFFE0,
                     'hFFE1, 'hFFE5, 'hFFE6, 'h2116};
  endfunction

  function automatic bit cls_space(longint c);
    return c inside {'h20, 'h3000};
  endfunction

  // Break opportunity between previous and current character
  function automatic bit may_break(longint p, longint c);
    if ((cls_latin(p) || cls_digit(p)) && (cls_latin(c) || cls_digit(c))) return 0;
    if (cls_space(c) || cls_punct(c)) return 0;
    if (cls_conn(p) || cls_conn(c)) return 0;
    if (cls_space(p) || cls_punct(p)) return 1;
    if (cls_prefix(p)) return 0;
    if (cls_prefix(c) || cls_cjk(c)) return 1;
    return cls_cjk(p);
  endfunction

  // Close one line: accumulate totals, record it while room is left
  function automatic void close_line(int first, int last);
    longint h;
    glb_pkg::out_item_t r;
    h = sec_height + run_a + sh_leading - run_d;
    if (h < 0) h = 0;
    if (h > SAT24) h = SAT24;
    sec_height = h;
    if (run_w > sec_width) sec_width = run_w;
    if (section_lines.size() < glb_pkg::RESULT_LIMIT) begin
      r = '0;
      r.line_first       = first[5:0];
      r.line_final       = last[5:0];
      r.line_width_out   = run_w[19:0];
      r.line_ascent_out  = run_a[14:0];
      r.line_descent_out = run_d[15:0];
      section_lines.push_back(r);
    end
  endfunction

  // Greedy breaking of the stored section into pending line results
  function automatic void break_into_lines();
    longint typeset, wid, bk_w, bk_a, bk_d;
    int scan, head, bk_at, on_line, opps, prv;
    bit opened, full;
    typeset = (sh_plate > sh_indent) ? sh_plate - sh_indent : 0;
    run_w = 0; run_a = 0; run_d = 0; on_line = 0; opps = 0;
    scan = 0; head = 0; bk_at = 0; opened = 0;
    bk_w = 0; bk_a = 0; bk_d = 0; sec_height = 0; sec_width = 0;
    section_lines.delete();
    while (scan < stored_chars) begin
      prv = (scan > 0) ? scan - 1 : 0;
      full = 0;
      wid = st_wid[scan];
      if (st_asc[scan] > run_a) run_a = st_asc[scan];
      if (st_dsc[scan] < run_d) run_d = st_dsc[scan];
      if (!opened) begin
        if (cls_open(st_code[scan])) begin
          opened = 1;
          full = 1;
        end else if (may_break(st_code[prv], st_code[scan])) begin
          full = 1;
        end
      end else if (!cls_space(st_code[scan]) && !cls_open(st_code[scan])) begin
        opened = 0;
      end
      if (full) begin
        if (on_line > 0) opps++;
        bk_at = scan; bk_w = run_w; bk_a = run_a; bk_d = run_d;
      end
      on_line++;
      if (sh_wrap_en && typeset > 0 && run_w + wid > typeset) begin
        // overflow: back up to the last opportunity on the line
        if (opps > 0) begin
          scan = bk_at; run_w = bk_w; run_a = bk_a; run_d = bk_d;
        end
        if (on_line == 1) begin
          run_w = wid;
          scan++;
        end
        close_line(head, scan - 1);
        head = scan;
        run_w = 0; run_a = 0; run_d = 0; on_line = 0; opps = 0;
      end else begin
        run_w += wid;
        if (run_w > SAT20) run_w = SAT20;
        scan++;
      end
    end
    if (head < stored_chars) close_line(head, stored_chars - 1);
    if (section_lines.size() > 0) begin
      section_lines[$].section_height = sec_height[23:0];
      section_lines[$].section_width  = sec_width[19:0];
      section_lines[$].final_line     = 1'b1;
    end
    foreach (section_lines[i]) pending_lines.push_back(section_lines[i]);
    stored_chars = 0;
  endfunction

  // Store an accepted character; the last one triggers breaking
  function automatic void load_char(glb_pkg::in_item_t it);
    if (stored_chars < STORE_DEPTH) begin
      st_code[stored_chars] = it.char_code;
      st_wid[stored_chars]  = it.char_width;
      st_asc[stored_chars]  = it.char_ascent;
      st_dsc[stored_chars]  = it.char_descent;
      stored_chars++;
    end
    if (it.last_char) begin
      break_into_lines();
      sections_sent++;
    end
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one character transaction and update the shadow store on accept
  task automatic send_char(glb_pkg::in_item_t it);
    int g;
    g = pick_gap(burst_in);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    load_char(it);
  endtask

  // Drain all lines, let the block settle, then program every register
  task automatic apply_setting(setting_t s);
    logic [19:0] vals[4];
    in_valid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    vals[0] = {19'($urandom_range(0, 'h7FFFF)), s.wrap_en};
    vals[1] = s.plate;
    vals[2] = s.indent;
    vals[3] = {4'($urandom_range(0, 15)), s.leading};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (2'(i))
        glb_pkg::REG_LIMIT_EN: sh_wrap_en = vals[i][0];
        glb_pkg::REG_PLATE:    sh_plate   = vals[i];
        glb_pkg::REG_INDENT:   sh_indent  = vals[i];
        glb_pkg::REG_LEADING:  sh_leading = longint'($signed(vals[i][15:0]));
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic glb_pkg::in_item_t mk_char(longint code, longint w, longint a,
                                                longint d, bit last);
    glb_pkg::in_item_t it;
    it.char_code    = code[15:0];
    it.char_width   = w[15:0];
    it.char_ascent  = a[14:0];
    it.char_descent = d[15:0];
    it.last_char    = last;
    return it;
  endfunction

  // Random character: mostly text, some class edge codes, some noise
  function automatic glb_pkg::in_item_t rand_char(bit last, longint wmax);
    longint pool[] = '{'h28, 'h5B, 'h7B, 'h01, 'h03, 'h06, 'h27, 'h2C, 'h2D, 'h2E, 'h2F,
                       'h21, 'h3F, 'h24, 'h80, 'hA3, 'h20AC, 'h2116, 'h4E00, 'hAC00,
                       'h3005, 'h300A, 'h3001, 'hFF62, 'hFF66, 'hFF08, 'h2018, 'hE9,
                       'h1E00, 'h3000, 'h0092, 'hFE69};
    longint code, w;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      code = $urandom_range('h61, 'h7A);
    else if (r < 55) code = $urandom_range('h30, 'h39);
    else if (r < 67) code = 'h20;
    else if (r < 82) code = pool[$urandom_range(0, pool.size() - 1)];
    else if (r < 90) code = $urandom_range('h4E00, 'h9FBF);
    else             code = $urandom_range(0, 'hFFFF);
    r = $urandom_range(0, 99);
    if (wide_mode && r < 30) w = $urandom_range('h8000, 'hFFFF);
    else if (r < 85)         w = $urandom_range('h10, wmax);
    else if (r < 90)         w = 0;
    else if (r < 95)         w = 'hFFFF;
    else                     w = $urandom_range(0, 'hFFFF);
    return mk_char(code, w, $urandom_range(0, 'h7FFF), -longint'($urandom_range(0, 32768)),
                   last);
  endfunction

  // Directed stimulus table
  typedef struct {
    int                 setting;   // setting to program first, -1 for none
    glb_pkg::in_item_t  it;
    bit                 typed;
    glb_pkg::out_item_t line;
  } row_t;

  row_t rows[$];

  function automatic void add_row(int s, glb_pkg::in_item_t it, bit typed = 0,
                                  glb_pkg::out_item_t line = '0);
    rows.push_back('{s, it, typed, line});
  endfunction

  task automatic run_directed();
    glb_pkg::out_item_t one;
    one = '{6'd0, 6'd0, 20'h10, 15'd5, -16'sd2, 24'd7, 20'h10, 1'b1};
    // single character section, wrapping off
    add_row(0, mk_char('h41, 'h10, 5, -2, 1), 1, one);
    // field extremes, one unwrapped line
    add_row(-1, mk_char('h0000, 0, 0, 0, 0));
    add_row(-1, mk_char('hFFFF, 'hFFFF, 'h7FFF, -32768, 0));
    add_row(-1, mk_char('h42, 'hFFFF, 1, 0, 0));
    add_row(-1, mk_char('h20, 'h8, 0, -1, 1));
    // words, a space, opening punctuation, wrapping on
    add_row(1, mk_char('h61, 'h30, 9, -3, 0));
    add_row(-1, mk_char('h62, 'h30, 8, -2, 0));
    add_row(-1, mk_char('h20, 'h30, 7, -1, 0));
    add_row(-1, mk_char('h63, 'h30, 12, -4, 0));
    add_row(-1, mk_char('h64, 'h30, 6, -2, 0));
    add_row(-1, mk_char('h28, 'h30, 6, -2, 0));
    add_row(-1, mk_char('h65, 'h30, 6, -2, 0));
    add_row(-1, mk_char('h66, 'h30, 6, -2, 1));
    // ideographs, prefix symbol, and one character wider than the line
    add_row(-1, mk_char('h4E00, 'h40, 14, -3, 0));
    add_row(-1, mk_char('h4E01, 'h40, 14, -3, 0));
    add_row(-1, mk_char('h3001, 'h40, 10, -2, 0));
    add_row(-1, mk_char('h24, 'h20, 10, -2, 0));
    add_row(-1, mk_char('h35, 'h20, 10, -2, 0));
    add_row(-1, mk_char('h57, 'h200, 20, -5, 1));
    // typeset width clamped to zero
    add_row(3, mk_char('h78, 'h100, 4, -1, 0));
    add_row(-1, mk_char('h79, 'h100, 4, -1, 1));
    foreach (rows[i]) begin
      if (rows[i].setting >= 0) apply_setting(settings[rows[i].setting]);
      send_char(rows[i].it);
      if (rows[i].typed) begin
        void'(pending_lines.pop_back());
        pending_lines.push_back(rows[i].line);
      end
    end
  endtask

  // Random sections, spread over settings 1 to 6
  task automatic run_random();
    int budget, len;
    longint wmax;
    bit filled;
    for (int s = 1; s < 7; s++) begin
      apply_setting(settings[s]);
      wmax   = (s == 4) ? 'h4000 : 'hC0;
      budget = 0;
      filled = 0;
      while (budget < 16) begin
        burst_in  = ($urandom_range(0, 3) == 0);
        wide_mode = ($urandom_range(0, 5) == 0);
        if ((s == 2 || s == 5) && !filled) begin
          len = STORE_DEPTH + 2;
          filled = 1;
        end else if ($urandom_range(0, 99) < 85) begin
          len = $urandom_range(1, 10);
        end else begin
          len = $urandom_range(11, 30);
        end
        for (int k = 0; k < len; k++) send_char(rand_char(k == len - 1, wmax));
        budget += len;
      end
    end
    in_valid <= 1'b0;
  endtask

  function automatic void check_field(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, e, a);
      errors++;
    end
  endfunction

  // Check line transactions, watch for a hang
  always @(posedge clk) begin
    glb_pkg::out_item_t e;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        lines_seen++;
        if (pending_lines.size() == 0) begin
          $display("%0t: unexpected line, expected none, actual %0h", $time, out_data);
          errors++;
        end else begin
          e = pending_lines.pop_front();
          check_field("line_first", e.line_first, out_data.line_first);
          check_field("line_final", e.line_final, out_data.line_final);
          check_field("line_width_out", e.line_width_out, out_data.line_width_out);
          check_field("line_ascent_out", e.line_ascent_out, out_data.line_ascent_out);
          check_field("line_descent_out", e.line_descent_out, out_data.line_descent_out);
          check_field("section_height", e.section_height, out_data.section_height);
          check_field("section_width", e.section_width, out_data.section_width);
          check_field("final_line", e.final_line, out_data.final_line);
        end
      end
    end
  end

  // Result side back-pressure: busy stretches, random stalls, long holds
  initial begin
    int thr;
    forever begin
      thr = $urandom_range(0, 2) == 0 ? 100 : $urandom_range(30, 90);
      repeat ($urandom_range(10, 60)) begin
        @(posedge clk);
        out_ready <= ($urandom_range(0, 99) < thr);
      end
      if ($urandom_range(0, 4) == 0) begin
        @(posedge clk);
        out_ready <= 1'b0;
        repeat ($urandom_range(15, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    sh_wrap_en = 0; sh_plate = 0; sh_indent = 0; sh_leading = 0;
    stored_chars = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d characters in %0d sections over 7 register settings,",
             chars_sent, sections_sent);
    $display("checked %0d line results, %0d errors", lines_seen, errors);
    if (errors == 0 && stored_chars == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/glb_pkg.sv
rtl/core/glb_store.sv
rtl/core/greedy_line_breaker.sv
rtl/core/glb_checker.sv
tb/sv/tb.sv
